### hdl/iirlp_pkg.sv
package iirlp_pkg;

    localparam int DATA_W    = 32;
    localparam int TAPS      = 5;
    localparam int FB_TAPS   = TAPS - 1;
    localparam int PROD_W    = 2 * DATA_W;
    // nine products of up to 2^62 each, plus the rounding constant
    localparam int ACC_W     = PROD_W + 4;
    // Q20.44 -> Q16.16
    localparam int RND_SHIFT = 28;
    localparam int RND_W     = ACC_W - RND_SHIFT;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0] t_word;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FF_OUTER  = 3'd0,
        CFG_FF_INNER  = 3'd1,
        CFG_FF_CENTER = 3'd2,
        CFG_FB_FIRST  = 3'd3,
        CFG_FB_SECOND = 3'd4,
        CFG_FB_THIRD  = 3'd5,
        CFG_FB_FOURTH = 3'd6,
        CFG_PEAK_THR  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_word ff_outer;
        t_word ff_inner;
        t_word ff_center;
        t_word fb_first;
        t_word fb_second;
        t_word fb_third;
        t_word fb_fourth;
        t_word peak_threshold;
    } t_coefs;

    localparam t_word RST_FF_OUTER  = 32'sd211617;
    localparam t_word RST_FF_INNER  = 32'sd858993;
    localparam t_word RST_FF_CENTER = 32'sd1261647;
    localparam t_word RST_FB_FIRST  = -32'sd883904270;
    localparam t_word RST_FB_SECOND = 32'sd1152715535;
    localparam t_word RST_FB_THIRD  = -32'sd699918608;
    localparam t_word RST_FB_FOURTH = 32'sd166456826;
    localparam t_word RST_PEAK_THR  = 32'sd78643;

    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN = 32'sh8000_0000;

endpackage

### hdl/iirlp_cfg_regs.sv
module iirlp_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [iirlp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [iirlp_pkg::DATA_W-1:0]        i_cfg_data,
    output iirlp_pkg::t_coefs                   o_coefs
);

    iirlp_pkg::t_coefs r_coefs;
    iirlp_pkg::t_coefs n_coefs;

    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_we) begin
            unique case (iirlp_pkg::t_cfg_idx'(i_cfg_index))
                iirlp_pkg::CFG_FF_OUTER:  n_coefs.ff_outer       = i_cfg_data;
                iirlp_pkg::CFG_FF_INNER:  n_coefs.ff_inner       = i_cfg_data;
                iirlp_pkg::CFG_FF_CENTER: n_coefs.ff_center      = i_cfg_data;
                iirlp_pkg::CFG_FB_FIRST:  n_coefs.fb_first       = i_cfg_data;
                iirlp_pkg::CFG_FB_SECOND: n_coefs.fb_second      = i_cfg_data;
                iirlp_pkg::CFG_FB_THIRD:  n_coefs.fb_third       = i_cfg_data;
                iirlp_pkg::CFG_FB_FOURTH: n_coefs.fb_fourth      = i_cfg_data;
                iirlp_pkg::CFG_PEAK_THR:  n_coefs.peak_threshold = i_cfg_data;
                default:                  n_coefs                = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.ff_outer       <= iirlp_pkg::RST_FF_OUTER;
            r_coefs.ff_inner       <= iirlp_pkg::RST_FF_INNER;
            r_coefs.ff_center      <= iirlp_pkg::RST_FF_CENTER;
            r_coefs.fb_first       <= iirlp_pkg::RST_FB_FIRST;
            r_coefs.fb_second      <= iirlp_pkg::RST_FB_SECOND;
            r_coefs.fb_third       <= iirlp_pkg::RST_FB_THIRD;
            r_coefs.fb_fourth      <= iirlp_pkg::RST_FB_FOURTH;
            r_coefs.peak_threshold <= iirlp_pkg::RST_PEAK_THR;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    assign o_coefs = r_coefs;

endmodule

### hdl/iirlp_mac.sv
module iirlp_mac (
    input  iirlp_pkg::t_coefs  i_coefs,
    input  iirlp_pkg::t_word   i_xh [iirlp_pkg::TAPS],
    input  iirlp_pkg::t_word   i_yh [iirlp_pkg::FB_TAPS],
    output iirlp_pkg::t_word   o_y
);

    iirlp_pkg::t_word                          w_ff_coef [iirlp_pkg::TAPS];
    iirlp_pkg::t_word                          w_fb_coef [iirlp_pkg::FB_TAPS];
    logic signed [iirlp_pkg::PROD_W-1:0]       w_ff_prod [iirlp_pkg::TAPS];
    logic signed [iirlp_pkg::PROD_W-1:0]       w_fb_prod [iirlp_pkg::FB_TAPS];
    logic signed [iirlp_pkg::ACC_W-1:0]        w_ff_sum;
    logic signed [iirlp_pkg::ACC_W-1:0]        w_fb_sum;
    logic signed [iirlp_pkg::ACC_W-1:0]        w_acc;
    logic signed [iirlp_pkg::RND_W-1:0]        w_rnd;
    logic                                      w_in_range;

    // symmetric feed-forward taps
    assign w_ff_coef[0] = i_coefs.ff_outer;
    assign w_ff_coef[1] = i_coefs.ff_inner;
    assign w_ff_coef[2] = i_coefs.ff_center;
    assign w_ff_coef[3] = i_coefs.ff_inner;
    assign w_ff_coef[4] = i_coefs.ff_outer;

    assign w_fb_coef[0] = i_coefs.fb_first;
    assign w_fb_coef[1] = i_coefs.fb_second;
    assign w_fb_coef[2] = i_coefs.fb_third;
    assign w_fb_coef[3] = i_coefs.fb_fourth;

    always_comb begin
        for (int i = 0; i < iirlp_pkg::TAPS; i++) begin
            w_ff_prod[i] = i_xh[i] * w_ff_coef[i];
        end
        for (int i = 0; i < iirlp_pkg::FB_TAPS; i++) begin
            w_fb_prod[i] = i_yh[i] * w_fb_coef[i];
        end
    end

    // exact Q20.44 sum, then add half an output LSB
    assign w_ff_sum = (iirlp_pkg::ACC_W'(w_ff_prod[0]) + iirlp_pkg::ACC_W'(w_ff_prod[1]))
                    + (iirlp_pkg::ACC_W'(w_ff_prod[2]) + iirlp_pkg::ACC_W'(w_ff_prod[3]))
                    + iirlp_pkg::ACC_W'(w_ff_prod[4]);
    assign w_fb_sum = (iirlp_pkg::ACC_W'(w_fb_prod[0]) + iirlp_pkg::ACC_W'(w_fb_prod[1]))
                    + (iirlp_pkg::ACC_W'(w_fb_prod[2]) + iirlp_pkg::ACC_W'(w_fb_prod[3]));
    assign w_acc    = w_ff_sum - w_fb_sum
                    + (iirlp_pkg::ACC_W'(1) <<< (iirlp_pkg::RND_SHIFT - 1));

    // floor to Q16.16
    assign w_rnd = w_acc[iirlp_pkg::ACC_W-1:iirlp_pkg::RND_SHIFT];

    // fits in 32 bits when all bits above the sign bit agree with it
    assign w_in_range = (&w_rnd[iirlp_pkg::RND_W-1:iirlp_pkg::DATA_W-1])
                     || !(|w_rnd[iirlp_pkg::RND_W-1:iirlp_pkg::DATA_W-1]);

    always_comb begin
        if (w_in_range) begin
            o_y = w_rnd[iirlp_pkg::DATA_W-1:0];
        end else if (w_rnd[iirlp_pkg::RND_W-1]) begin
            o_y = iirlp_pkg::WORD_MIN;
        end else begin
            o_y = iirlp_pkg::WORD_MAX;
        end
    end

endmodule

### hdl/iirlp_peak.sv
module iirlp_peak (
    input  iirlp_pkg::t_word  i_yh [iirlp_pkg::TAPS],
    input  iirlp_pkg::t_word  i_threshold,
    output logic              o_peak
);

    // index 0 is the newest output; the middle one must stand above both sides
    assign o_peak = (i_yh[0] < i_yh[1])
                 && (i_yh[1] < i_yh[2])
                 && (i_yh[2] > i_yh[3])
                 && (i_yh[3] > i_yh[4])
                 && (i_yh[2] > i_threshold);

endmodule

### hdl/iir_lowpass_with_peak_detect_unit.sv
// Channel   Direction  Handshake                          Payload
// sample    in         i_sample_valid / o_sample_ready    i_sample_in (Q16.16)
// result    out        o_result_valid / i_result_ready    o_filtered_out, o_peak_found
// config    in         i_cfg_we (write only, no wait)     i_cfg_index, i_cfg_data
//
// One sample per cycle sustained while the result side is ready; a result is
// registered in turn by the input history, the filter's output history and the
// output register before it is presented.
// The cycle time is set by the output-history loop: nine 32x32 products, the
// 68-bit sum, rounding and saturation all sit between the history registers.
// Synchronous active-low reset clears both histories and loads the default
// coefficients; no clearing pass is needed.
// A stall on the result side backs up stage by stage; o_sample_ready only
// drops when all three stages hold a transaction.
module iir_lowpass_with_peak_detect_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_sample_valid,
    output logic                                o_sample_ready,
    input  logic signed [iirlp_pkg::DATA_W-1:0] i_sample_in,
    // result channel
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    output logic signed [iirlp_pkg::DATA_W-1:0] o_filtered_out,
    output logic                                o_peak_found,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [iirlp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [iirlp_pkg::DATA_W-1:0]        i_cfg_data
);

    iirlp_pkg::t_coefs  w_coefs;

    // stage A: input history, newest first; valid means a sample is waiting
    iirlp_pkg::t_word   r_xh [iirlp_pkg::TAPS];
    logic               r_a_vld;
    // stage B: output history, newest first; valid means r_yh[0] not yet sent
    iirlp_pkg::t_word   r_yh [iirlp_pkg::TAPS];
    logic               r_b_vld;
    // stage C: output register
    iirlp_pkg::t_word   r_out_y;
    logic               r_out_pk;
    logic               r_c_vld;

    iirlp_pkg::t_word   w_yfb [iirlp_pkg::FB_TAPS];
    iirlp_pkg::t_word   w_y;
    logic               w_peak;

    logic               w_c_ready;
    logic               w_b_ready;
    logic               w_a_ready;
    logic               w_in_xact;
    logic               w_a_to_b;
    logic               w_b_to_c;

    // ---------------- handshake chain ----------------
    assign w_c_ready = !r_c_vld || i_result_ready;
    assign w_b_to_c  = r_b_vld && w_c_ready;
    assign w_b_ready = !r_b_vld || w_c_ready;
    assign w_a_to_b  = r_a_vld && w_b_ready;
    assign w_a_ready = !r_a_vld || w_b_ready;
    assign w_in_xact = i_sample_valid && w_a_ready;

    assign o_sample_ready = w_a_ready;

    // ---------------- configuration ----------------
    iirlp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (w_coefs)
    );

    // ---------------- stage A: take the sample into the input history ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            for (int i = 0; i < iirlp_pkg::TAPS; i++) begin
                r_xh[i] <= '0;
            end
        end else begin
            if (w_in_xact) begin
                r_a_vld <= 1'b1;
                r_xh[0] <= i_sample_in;
                for (int i = 1; i < iirlp_pkg::TAPS; i++) begin
                    r_xh[i] <= r_xh[i-1];
                end
            end else if (w_a_to_b) begin
                r_a_vld <= 1'b0;
            end
        end
    end

    // ---------------- stage B: filter arithmetic ----------------
    // feedback uses the four newest outputs before this one is pushed
    always_comb begin
        for (int i = 0; i < iirlp_pkg::FB_TAPS; i++) begin
            w_yfb[i] = r_yh[i];
        end
    end

    iirlp_mac u_mac (
        .i_coefs (w_coefs),
        .i_xh    (r_xh),
        .i_yh    (w_yfb),
        .o_y     (w_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            for (int i = 0; i < iirlp_pkg::TAPS; i++) begin
                r_yh[i] <= '0;
            end
        end else begin
            if (w_a_to_b) begin
                r_b_vld <= 1'b1;
                r_yh[0] <= w_y;
                for (int i = 1; i < iirlp_pkg::TAPS; i++) begin
                    r_yh[i] <= r_yh[i-1];
                end
            end else if (w_b_to_c) begin
                r_b_vld <= 1'b0;
            end
        end
    end

    // ---------------- stage C: peak flag and output register ----------------
    // peak is judged on the history with the new output already pushed
    iirlp_peak u_peak (
        .i_yh        (r_yh),
        .i_threshold (w_coefs.peak_threshold),
        .o_peak      (w_peak)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            if (w_b_to_c) begin
                r_c_vld <= 1'b1;
            end else if (i_result_ready) begin
                r_c_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_to_c) begin
            r_out_y  <= r_yh[0];
            r_out_pk <= w_peak;
        end
    end

    assign o_result_valid = r_c_vld;
    assign o_filtered_out = r_out_y;
    assign o_peak_found   = r_out_pk;

    // ---------------- assertions ----------------
    // input backs up only when every stage is occupied
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_sample_ready |-> (r_a_vld && r_b_vld && r_c_vld))
        else $error("sample ready dropped with a free stage");

    // a sample transaction lands at the head of the input history
    a_xh_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xact |=> (r_xh[0] == $past(i_sample_in)))
        else $error("input history head does not match accepted sample");

    // a filter step shifts the output history by exactly one place
    a_yh_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_a_to_b |=> (r_yh[1] == $past(r_yh[0]) && r_b_vld))
        else $error("output history did not shift on filter step");

    // a transfer into the output register loads the newest filtered value
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_b_to_c |=> (o_result_valid && o_filtered_out == $past(r_yh[0])))
        else $error("output register lost the newest filtered value");

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_sample_valid = 1'b0;
    iirlp_pkg::t_word                i_sample_in    = '0;
    logic                            i_result_ready = 1'b0;
    logic                            i_cfg_we       = 1'b0;
    logic [iirlp_pkg::CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [iirlp_pkg::DATA_W-1:0]    i_cfg_data     = '0;
    logic                            o_sample_ready;
    logic                            o_result_valid;
    iirlp_pkg::t_word                o_filtered_out;
    logic                            o_peak_found;

    iir_lowpass_with_peak_detect_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample_in    (i_sample_in),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_filtered_out (o_filtered_out),
        .o_peak_found   (o_peak_found),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Filter model: coefficients plus both histories, newest first
    // ------------------------------------------------------------------
    typedef struct {
        iirlp_pkg::t_word filtered;
        logic             peak;
    } t_filter_result;

    typedef enum int {COEF_DEFAULT, COEF_SMOOTH, COEF_WILD, COEF_CORNER} t_coef_mode;
    typedef enum int {SHAPE_FULL, SHAPE_SMALL, SHAPE_BURSTS} t_shape;

    localparam logic signed [71:0] SAT_HI   = 72'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [71:0] SAT_LO   = -72'sh0_0000_0000_8000_0000;
    localparam logic signed [71:0] HALF_LSB = 72'sd134217728;  // 2^27
    localparam iirlp_pkg::t_word   ONE_Q28  = 32'sh1000_0000;

    iirlp_pkg::t_coefs model_coefs = '{iirlp_pkg::RST_FF_OUTER, iirlp_pkg::RST_FF_INNER,
                                       iirlp_pkg::RST_FF_CENTER, iirlp_pkg::RST_FB_FIRST,
                                       iirlp_pkg::RST_FB_SECOND, iirlp_pkg::RST_FB_THIRD,
                                       iirlp_pkg::RST_FB_FOURTH, iirlp_pkg::RST_PEAK_THR};
    iirlp_pkg::t_word  x_hist [iirlp_pkg::TAPS] = '{default: '0};
    iirlp_pkg::t_word  y_hist [iirlp_pkg::TAPS] = '{default: '0};

    t_filter_result   expected_results [$];
    iirlp_pkg::t_word sample_plan [$];

    int  fail_count      = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  peaks_seen      = 0;
    int  settings_loaded = 0;
    int  hold_off_cycles = 0;  // receiver hold-off request, counted down below
    bit  calm            = 1'b0;  // no random idling on either side while set

    // Advance the model by one sample and return the result it predicts.
    function automatic t_filter_result filter_step(input iirlp_pkg::t_word x);
        iirlp_pkg::t_word   ff [iirlp_pkg::TAPS];
        iirlp_pkg::t_word   fb [iirlp_pkg::FB_TAPS];
        logic signed [71:0] acc;
        logic signed [71:0] rounded;
        t_filter_result     res;
        ff = '{model_coefs.ff_outer, model_coefs.ff_inner, model_coefs.ff_center,
               model_coefs.ff_inner, model_coefs.ff_outer};
        fb = '{model_coefs.fb_first, model_coefs.fb_second,
               model_coefs.fb_third, model_coefs.fb_fourth};
        for (int i = iirlp_pkg::TAPS - 1; i > 0; i--) x_hist[i] = x_hist[i-1];
        x_hist[0] = x;
        acc = '0;
        for (int i = 0; i < iirlp_pkg::TAPS; i++)
            acc = acc + (longint'(x_hist[i]) * longint'(ff[i]));
        for (int i = 0; i < iirlp_pkg::FB_TAPS; i++)
            acc = acc - (longint'(y_hist[i]) * longint'(fb[i]));
        // Q20.44 -> Q16.16, ties toward plus infinity
        rounded = (acc + HALF_LSB) >>> iirlp_pkg::RND_SHIFT;
        if (rounded > SAT_HI)
            res.filtered = iirlp_pkg::WORD_MAX;
        else if (rounded < SAT_LO)
            res.filtered = iirlp_pkg::WORD_MIN;
        else
            res.filtered = rounded[iirlp_pkg::DATA_W-1:0];
        for (int i = iirlp_pkg::TAPS - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
        y_hist[0] = res.filtered;
        // middle of the five newest outputs: strict local max above threshold
        res.peak = (y_hist[0] < y_hist[1]) && (y_hist[1] < y_hist[2]) &&
                   (y_hist[2] > y_hist[3]) && (y_hist[3] > y_hist[4]) &&
                   (y_hist[2] > model_coefs.peak_threshold);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic iirlp_pkg::t_word small_rand(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Called at a rising edge; returns at the edge where the
    // transaction was accepted. Valid is left high so back-to-back items
    // never drop and raise it in the same step.
    // ------------------------------------------------------------------
    task automatic send_sample(input iirlp_pkg::t_word s);
        int gap;
        gap = calm ? 0 : random_gap();
        if (gap > 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample_in    <= s;
        do @(posedge i_clk); while (!o_sample_ready);
        expected_results.push_back(filter_step(s));
        items_sent++;
    endtask

    task automatic send_plan();
        while (sample_plan.size() != 0)
            send_sample(sample_plan.pop_front());
    endtask

    // Drain the pipe until every expected result is checked, then idle spare cycles.
    task automatic wait_idle();
        i_sample_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input iirlp_pkg::t_cfg_idx idx, input iirlp_pkg::t_word val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            iirlp_pkg::CFG_FF_OUTER:  model_coefs.ff_outer       = val;
            iirlp_pkg::CFG_FF_INNER:  model_coefs.ff_inner       = val;
            iirlp_pkg::CFG_FF_CENTER: model_coefs.ff_center      = val;
            iirlp_pkg::CFG_FB_FIRST:  model_coefs.fb_first       = val;
            iirlp_pkg::CFG_FB_SECOND: model_coefs.fb_second      = val;
            iirlp_pkg::CFG_FB_THIRD:  model_coefs.fb_third       = val;
            iirlp_pkg::CFG_FB_FOURTH: model_coefs.fb_fourth      = val;
            iirlp_pkg::CFG_PEAK_THR:  model_coefs.peak_threshold = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Full coefficient set, only once the block is idle.
    task automatic load_coefs(input iirlp_pkg::t_coefs c);
        wait_idle();
        write_reg(iirlp_pkg::CFG_FF_OUTER,  c.ff_outer);
        write_reg(iirlp_pkg::CFG_FF_INNER,  c.ff_inner);
        write_reg(iirlp_pkg::CFG_FF_CENTER, c.ff_center);
        write_reg(iirlp_pkg::CFG_FB_FIRST,  c.fb_first);
        write_reg(iirlp_pkg::CFG_FB_SECOND, c.fb_second);
        write_reg(iirlp_pkg::CFG_FB_THIRD,  c.fb_third);
        write_reg(iirlp_pkg::CFG_FB_FOURTH, c.fb_fourth);
        write_reg(iirlp_pkg::CFG_PEAK_THR,  c.peak_threshold);
        settings_loaded++;
    endtask

    function automatic iirlp_pkg::t_coefs uniform_coefs(input iirlp_pkg::t_word v);
        return '{v, v, v, v, v, v, v, v};
    endfunction

    function automatic iirlp_pkg::t_coefs random_coefs(input t_coef_mode mode);
        iirlp_pkg::t_coefs c;
        iirlp_pkg::t_word  corner [5];
        corner = '{iirlp_pkg::WORD_MAX, iirlp_pkg::WORD_MIN, '0, ONE_Q28, -32'sd1};
        case (mode)
            COEF_DEFAULT: begin
                c = '{iirlp_pkg::RST_FF_OUTER, iirlp_pkg::RST_FF_INNER,
                      iirlp_pkg::RST_FF_CENTER, iirlp_pkg::RST_FB_FIRST,
                      iirlp_pkg::RST_FB_SECOND, iirlp_pkg::RST_FB_THIRD,
                      iirlp_pkg::RST_FB_FOURTH, iirlp_pkg::RST_PEAK_THR};
            end
            COEF_SMOOTH: begin
                // stable: feedback gains at most 1/8 each
                c.ff_outer       = small_rand(1 << 26);
                c.ff_inner       = $urandom_range(0, 1 << 27);
                c.ff_center      = $urandom_range(0, 1 << 28);
                c.fb_first       = small_rand(1 << 25);
                c.fb_second      = small_rand(1 << 25);
                c.fb_third       = small_rand(1 << 25);
                c.fb_fourth      = small_rand(1 << 25);
                c.peak_threshold = small_rand(1 << 20);
            end
            COEF_WILD: begin
                c = '{$urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom};
            end
            default: begin
                c.ff_outer       = corner[$urandom_range(0, 4)];
                c.ff_inner       = corner[$urandom_range(0, 4)];
                c.ff_center      = corner[$urandom_range(0, 4)];
                c.fb_first       = corner[$urandom_range(0, 4)];
                c.fb_second      = corner[$urandom_range(0, 4)];
                c.fb_third       = corner[$urandom_range(0, 4)];
                c.fb_fourth      = corner[$urandom_range(0, 4)];
                c.peak_threshold = corner[$urandom_range(0, 4)];
            end
        endcase
        return c;
    endfunction

    // Bursts: rising/falling ramps make peaks, some raw noise mixed in; else random words.
    task automatic plan_samples(input t_shape shape, input int count);
        int level;
        int step;
        int len;
        while (sample_plan.size() < count) begin
            if (shape == SHAPE_FULL) begin
                sample_plan.push_back($urandom);
            end else if (shape == SHAPE_SMALL) begin
                sample_plan.push_back(small_rand(1 << 20));
            end else if ($urandom_range(0, 99) < 15) begin
                sample_plan.push_back($urandom);
            end else begin
                level = small_rand(1 << 19);
                step  = $urandom_range(1, 1 << 18);
                len   = $urandom_range(2, 8);
                repeat (len) begin
                    level += step;
                    sample_plan.push_back(level);
                end
                repeat (len) begin
                    level -= step;
                    sample_plan.push_back(level);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, a requested hold-off takes priority
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_ready_drive
        int stall_left;
        if (!i_rst_n) begin
            i_result_ready <= 1'b0;
            stall_left = 0;
        end else if (hold_off_cycles > 0) begin
            i_result_ready <= 1'b0;
            hold_off_cycles--;
        end else if (stall_left > 0) begin
            i_result_ready <= 1'b0;
            stall_left--;
        end else begin
            i_result_ready <= 1'b1;
            stall_left = calm ? 0 : random_gap();
        end
    end

    // Each result transaction against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_filter_result want;
        if (i_rst_n && o_result_valid && i_result_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: filtered_out=%0d peak_found=%0b",
                       o_filtered_out, o_peak_found);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.peak) peaks_seen++;
                if (o_filtered_out !== want.filtered) begin
                    $error("filtered_out: expected %0d, actual %0d",
                           want.filtered, o_filtered_out);
                    fail_count++;
                end
                if (o_peak_found !== want.peak) begin
                    $error("peak_found: expected %0b, actual %0b",
                           want.peak, o_peak_found);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset coefficients, sample extremes
    task automatic test_reset_defaults();
        send_sample(iirlp_pkg::WORD_MAX);
        send_sample(iirlp_pkg::WORD_MIN);
        send_sample('0);
        send_sample(-32'sd1);
        send_sample(32'sd1);
    endtask

    // Gain 1/2 on the middle tap: odd inputs land exactly on half an LSB
    task automatic test_rounding_ties();
        iirlp_pkg::t_coefs c;
        c = uniform_coefs('0);
        c.ff_center = ONE_Q28 >>> 1;
        load_coefs(c);
        send_sample(32'sd1);
        send_sample(-32'sd1);
        send_sample(32'sd3);
        send_sample(-32'sd3);
        send_sample('0);
        send_sample('0);
    endtask

    // Unit gain, two-sample delay; peak above threshold, one below, a plateau
    task automatic test_peak_shapes();
        iirlp_pkg::t_coefs c;
        c = uniform_coefs('0);
        c.ff_center      = ONE_Q28;
        c.peak_threshold = 32'sh0002_0000;
        load_coefs(c);
        sample_plan = '{32'sh0001_0000, 32'sh0003_0000, 32'sh0005_0000,
                        32'sh0003_0000, 32'sh0001_0000,
                        32'sh0000_4000, 32'sh0000_8000, 32'sh0000_C000,
                        32'sh0000_8000, 32'sh0000_4000,
                        32'sh0003_0000, 32'sh0003_0000, 32'sh0001_0000,
                        32'sh0000_0000, 32'sh0000_0000};
        send_plan();
    endtask

    // All coefficients at one extreme: the sum saturates both ways
    task automatic test_coef_extremes();
        load_coefs(uniform_coefs(iirlp_pkg::WORD_MAX));
        send_sample(iirlp_pkg::WORD_MAX);
        send_sample(iirlp_pkg::WORD_MIN);
        load_coefs(uniform_coefs(iirlp_pkg::WORD_MIN));
        send_sample(iirlp_pkg::WORD_MAX);
        send_sample(iirlp_pkg::WORD_MIN);
    endtask

    // Phases of random settings and sample shapes, bursts weighted up
    task automatic test_random_phases();
        int         start_count;
        int         n;
        int         r;
        t_coef_mode mode;
        t_shape     shape;
        start_count = items_sent;
        while (items_sent - start_count < 1000) begin
            mode = t_coef_mode'($urandom_range(0, 3));
            r    = $urandom_range(0, 9);
            shape = (r < 5) ? SHAPE_BURSTS : (r < 8) ? SHAPE_FULL : SHAPE_SMALL;
            load_coefs(random_coefs(mode));
            calm = ($urandom_range(0, 4) == 0);
            n = $urandom_range(40, 120);
            plan_samples(shape, n);
            send_plan();
        end
        calm = 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering: the pipe fills
    // and o_sample_ready must drop until the receiver comes back.
    task automatic test_backpressure();
        load_coefs(random_coefs(COEF_DEFAULT));
        calm = 1'b1;
        hold_off_cycles = 150;
        plan_samples(SHAPE_BURSTS, 30);
        send_plan();
        calm = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_rounding_ties();
        test_peak_shapes();
        test_coef_extremes();
        test_random_phases();
        test_backpressure();

        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("Checked %0d results from %0d sample transactions, %0d peaks flagged,",
                 results_checked, items_sent, peaks_seen);
        $display("across %0d coefficient sets incl. saturation, ties and a long stall.",
                 settings_loaded);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("iir_lowpass_with_peak_detect_unit test passed");
        end else begin
            $display("iir_lowpass_with_peak_detect_unit test failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("iir_lowpass_with_peak_detect_unit test failed");
        $finish;
    end

endmodule
